>>> design/trhc_pkg.sv
// Package for the top-k recall hit counter: field widths, parameter defaults,
// action and register codes, and the structs passed between the submodules.
// Depends on nothing; every other design file imports it.
package trhc_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_TRUTH_DEF      = 64;
  localparam int unsigned TOPK_SLOTS_DEF     = 4;
  localparam int unsigned MAX_CANDIDATES_DEF = 256;
  localparam int unsigned COUNTER_BITS_DEF   = 32;

  // Number of depth registers, and the most slots a counter row can hold.
  localparam int unsigned K_REGS     = 4;
  localparam int unsigned SLOT_LIMIT = 8;

  // Field widths fixed by the interface.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned INDEX_W    = 31;
  localparam int unsigned RANK_W     = 8;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned SLOTS_W    = 3;
  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned CAND_W     = 9;
  localparam int unsigned TRUTH_W    = INDEX_W + 1;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NEW   = 2'd0,
    ACT_TRUTH = 2'd1,
    ACT_CAND  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOTS  = 3'd0,
    REG_TOPK0  = 3'd1,
    REG_TOPK1  = 3'd2,
    REG_TOPK2  = 3'd3,
    REG_TOPK3  = 3'd4,
    REG_CANDS  = 3'd5,
    REG_DBSIZE = 3'd6
  } reg_e;

  // Classified command, as the back end executes it.
  typedef enum logic [2:0] {
    OP_NEW,
    OP_TRUTH,
    OP_CAND,
    OP_READ,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               bad;
    logic [INDEX_W-1:0] idx;
    logic [RANK_W-1:0]  rank;
    logic [SEL_W-1:0]   sel;
  } cmd_t;

  // Decoded configuration, shared by front and back.
  typedef struct packed {
    logic [K_REGS-1:0]              active;
    logic [K_REGS-1:0][DEPTH_W-1:0] depth;
    logic [CAND_W-1:0]              cand_lim;
    logic [INDEX_W-1:0]             db_size;
  } cfg_t;

endpackage

>>> design/trhc_cfg_regs.sv
// Configuration register file of the top-k recall hit counter.
// Holds the seven registers and decodes the active slot mask. Uses trhc_pkg.
module trhc_cfg_regs
  import trhc_pkg::*;
#(
  parameter int unsigned TOPK_SLOTS = TOPK_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [SLOTS_W-1:0]             slots_q;
  logic [K_REGS-1:0][DEPTH_W-1:0] depth_q;
  logic [CAND_W-1:0]              cands_q;
  logic [INDEX_W-1:0]             dbsize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SLOTS_W'(1);
      depth_q  <= {K_REGS{DEPTH_W'(1)}};
      cands_q  <= CAND_W'(256);
      dbsize_q <= {INDEX_W{1'b1}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOTS:  slots_q    <= cfg_data_i[SLOTS_W-1:0];
        REG_TOPK0:  depth_q[0] <= cfg_data_i[DEPTH_W-1:0];
        REG_TOPK1:  depth_q[1] <= cfg_data_i[DEPTH_W-1:0];
        REG_TOPK2:  depth_q[2] <= cfg_data_i[DEPTH_W-1:0];
        REG_TOPK3:  depth_q[3] <= cfg_data_i[DEPTH_W-1:0];
        REG_CANDS:  cands_q    <= cfg_data_i[CAND_W-1:0];
        REG_DBSIZE: dbsize_q   <= cfg_data_i[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // A slot is active when it is below both the programmed count and TOPK_SLOTS.
  always_comb begin
    for (int s = 0; s < K_REGS; s++) begin
      cfg_o.active[s] = (32'(s) < 32'(slots_q)) && (32'(s) < 32'(TOPK_SLOTS));
    end
    cfg_o.depth    = depth_q;
    cfg_o.cand_lim = cands_q;
    cfg_o.db_size  = dbsize_q;
  end

endmodule

>>> design/trhc_front.sv
// Front end of the top-k recall hit counter: input handshake and classification.
// Range checks that depend only on configuration are settled here. Uses trhc_pkg.
module trhc_front
  import trhc_pkg::*;
#(
  parameter int unsigned TOPK_SLOTS     = TOPK_SLOTS_DEF,
  parameter int unsigned MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [INDEX_W-1:0] point_index_i,
  input  logic [RANK_W-1:0]  rank_position_i,
  input  logic [SEL_W-1:0]   slot_select_i,
  input  cfg_t               cfg_i,
  input  logic               busy_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cmd_t               q_item_o
);

  logic idx_bad;
  logic rank_over;

  assign in_stall_o = busy_i || q_full_i;
  assign q_push_o   = in_valid_i && !in_stall_o;

  always_comb begin
    idx_bad   = point_index_i >= cfg_i.db_size;
    rank_over = 32'(rank_position_i) >= 32'(MAX_CANDIDATES);

    q_item_o.bad  = idx_bad;
    q_item_o.idx  = point_index_i;
    q_item_o.rank = rank_position_i;
    q_item_o.sel  = slot_select_i;

    case (action_i)
      ACT_NEW:   q_item_o.op = OP_NEW;
      ACT_TRUTH: q_item_o.op = OP_TRUTH;
      ACT_CAND: begin
        if (rank_over || (CAND_W'(rank_position_i) >= cfg_i.cand_lim) || idx_bad) begin
          q_item_o.op = OP_REJECT;
        end else begin
          q_item_o.op = OP_CAND;
        end
      end
      ACT_READ: begin
        if (rank_over || (32'(slot_select_i) >= 32'(TOPK_SLOTS))) begin
          q_item_o.op = OP_REJECT;
        end else begin
          q_item_o.op = OP_READ;
        end
      end
      default:   q_item_o.op = OP_REJECT;
    endcase
  end

endmodule

>>> design/trhc_queue.sv
// Short command queue between the front and back ends of the hit counter.
// Register-based FIFO of classified commands. Uses trhc_pkg.
module trhc_queue
  import trhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t item_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t item_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
      end
      if (do_pop) begin
        rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
      end
      if (do_push && !do_pop) begin
        cnt_q <= QCNT_W'(cnt_q + QCNT_W'(1));
      end else if (do_pop && !do_push) begin
        cnt_q <= QCNT_W'(cnt_q - QCNT_W'(1));
      end
    end
  end

endmodule

>>> design/trhc_back.sv
// Back end of the top-k recall hit counter: ground-truth memory, scan sequencer,
// counter memory with read-modify-write, and the output register. Uses trhc_pkg.
module trhc_back
  import trhc_pkg::*;
#(
  parameter int unsigned MAX_TRUTH      = MAX_TRUTH_DEF,
  parameter int unsigned TOPK_SLOTS     = TOPK_SLOTS_DEF,
  parameter int unsigned MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int unsigned COUNTER_BITS   = COUNTER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  cmd_t               q_item_i,
  output logic               q_pop_o,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MASK_W-1:0]  hit_mask_o,
  output logic [VALUE_W-1:0] counter_value_o,
  output logic               error_o
);

  localparam int unsigned TA_W  = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int unsigned TC_W  = $clog2(MAX_TRUTH + 1);
  localparam int unsigned LW    = (TC_W > DEPTH_W) ? TC_W : DEPTH_W;
  localparam int unsigned RA_W  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned CB    = COUNTER_BITS;
  localparam int unsigned ROW_W = TOPK_SLOTS * CB;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CUPD,
    S_RDOUT
  } state_e;

  function automatic logic [RA_W-1:0] to_addr(input logic [RANK_W-1:0] r);
    logic [31:0] w;
    w = 32'(r);
    return w[RA_W-1:0];
  endfunction

  // Memories.
  logic [TRUTH_W-1:0] truth_mem [MAX_TRUTH];
  logic [ROW_W-1:0]   cnt_mem   [MAX_CANDIDATES];
  logic [TRUTH_W-1:0] truth_rdata_q;
  logic [ROW_W-1:0]   cnt_row_q;

  logic               truth_we;
  logic [TA_W-1:0]    truth_waddr;
  logic [TRUTH_W-1:0] truth_wdata;
  logic [TA_W-1:0]    truth_raddr;
  logic               cnt_we;
  logic [RA_W-1:0]    cnt_waddr;
  logic [ROW_W-1:0]   cnt_wdata;
  logic               cnt_re;
  logic [RA_W-1:0]    cnt_raddr;

  // Sequencer state and output register.
  state_e             state_q, state_d;
  logic [TC_W-1:0]    count_q, count_d;
  logic [RA_W-1:0]    clr_q, clr_d;
  logic [TA_W-1:0]    cmp_q, cmp_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [SEL_W-1:0]   sel_q, sel_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic               out_valid_q, out_valid_d;
  logic [MASK_W-1:0]  out_mask_q, out_mask_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_err_q, out_err_d;

  // Derived values.
  logic [TC_W-1:0]       lim [K_REGS];
  logic [TC_W-1:0]       scan_lim;
  logic [MASK_W-1:0]     hit_vec;
  logic                  entry_match;
  logic                  full;
  logic                  out_free;
  logic [ROW_W-1:0]      new_row;
  logic [CB-1:0]         rd_val;
  logic [63:0]           rd_val_ext;

  always_ff @(posedge clk_i) begin
    if (truth_we) begin
      truth_mem[truth_waddr] <= truth_wdata;
    end
    truth_rdata_q <= truth_mem[truth_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_row_q <= cnt_mem[cnt_raddr];
    end
  end

  // Per-slot search depth is the smaller of its k and the entries held so far.
  always_comb begin
    logic [LW-1:0] kx;
    logic [LW-1:0] cx;
    scan_lim = '0;
    for (int s = 0; s < K_REGS; s++) begin
      kx = LW'(cfg_i.depth[s]);
      cx = LW'(count_q);
      lim[s] = (kx < cx) ? kx[TC_W-1:0] : count_q;
      if (cfg_i.active[s] && (lim[s] > scan_lim)) begin
        scan_lim = lim[s];
      end
    end
  end

  // The scan stops at the first match, so a slot hits when that entry lies
  // inside its own depth.
  always_comb begin
    for (int s = 0; s < K_REGS; s++) begin
      hit_vec[s] = cfg_i.active[s] && (TC_W'(cmp_q) < lim[s]);
    end
  end

  assign entry_match = !truth_rdata_q[INDEX_W] && (truth_rdata_q[INDEX_W-1:0] == idx_q);
  assign full        = count_q == TC_W'(MAX_TRUTH);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Saturating increment of the hit slots of one row, and read-back selection.
  always_comb begin
    logic [SLOT_LIMIT-1:0] mask_w;
    logic [CB-1:0]         c;
    mask_w = SLOT_LIMIT'(mask_q);
    rd_val = '0;
    for (int s = 0; s < TOPK_SLOTS; s++) begin
      c = cnt_row_q[s*CB +: CB];
      if (32'(s) == 32'(sel_q)) begin
        rd_val = c;
      end
      if (mask_w[s] && (c != {CB{1'b1}})) begin
        c = CB'(c + CB'(1));
      end
      new_row[s*CB +: CB] = c;
    end
    rd_val_ext = 64'(rd_val);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    clr_d       = clr_q;
    cmp_d       = cmp_q;
    idx_d       = idx_q;
    rank_d      = rank_q;
    sel_d       = sel_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_mask_d  = out_mask_q;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;

    q_pop_o     = 1'b0;
    truth_we    = 1'b0;
    truth_waddr = count_q[TA_W-1:0];
    truth_wdata = {q_item_i.bad, q_item_i.idx};
    truth_raddr = (state_q == S_SCAN) ? TA_W'(cmp_q + TA_W'(1)) : '0;
    cnt_we      = 1'b0;
    cnt_waddr   = to_addr(rank_q);
    cnt_wdata   = new_row;
    cnt_re      = 1'b0;
    cnt_raddr   = to_addr(rank_q);

    case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        if (clr_q == RA_W'(MAX_CANDIDATES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = RA_W'(clr_q + RA_W'(1));
        end
      end
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          idx_d   = q_item_i.idx;
          rank_d  = q_item_i.rank;
          sel_d   = q_item_i.sel;
          case (q_item_i.op)
            OP_NEW: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              out_mask_d  = '0;
              out_value_d = '0;
              out_err_d   = 1'b0;
            end
            OP_TRUTH: begin
              out_valid_d = 1'b1;
              out_mask_d  = '0;
              out_value_d = '0;
              if (full) begin
                out_err_d = 1'b1;
              end else begin
                truth_we  = 1'b1;
                count_d   = TC_W'(count_q + TC_W'(1));
                out_err_d = q_item_i.bad;
              end
            end
            OP_CAND: begin
              if (scan_lim == '0) begin
                out_valid_d = 1'b1;
                out_mask_d  = '0;
                out_value_d = '0;
                out_err_d   = 1'b0;
              end else begin
                cmp_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_READ: begin
              cnt_re    = 1'b1;
              cnt_raddr = to_addr(q_item_i.rank);
              state_d   = S_RDOUT;
            end
            default: begin
              out_valid_d = 1'b1;
              out_mask_d  = '0;
              out_value_d = '0;
              out_err_d   = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (entry_match) begin
          mask_d    = hit_vec;
          cnt_re    = 1'b1;
          cnt_raddr = to_addr(rank_q);
          state_d   = S_CUPD;
        end else if (TC_W'(TC_W'(cmp_q) + TC_W'(1)) == scan_lim) begin
          out_valid_d = 1'b1;
          out_mask_d  = '0;
          out_value_d = '0;
          out_err_d   = 1'b0;
          state_d     = S_IDLE;
        end else begin
          cmp_d = TA_W'(cmp_q + TA_W'(1));
        end
      end
      S_CUPD: begin
        cnt_we      = 1'b1;
        out_valid_d = 1'b1;
        out_mask_d  = mask_q;
        out_value_d = '0;
        out_err_d   = 1'b0;
        state_d     = S_IDLE;
      end
      S_RDOUT: begin
        out_valid_d = 1'b1;
        out_mask_d  = '0;
        out_value_d = rd_val_ext[VALUE_W-1:0];
        out_err_d   = 1'b0;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      clr_q       <= '0;
      cmp_q       <= '0;
      idx_q       <= '0;
      rank_q      <= '0;
      sel_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_value_q <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      cmp_q       <= cmp_d;
      idx_q       <= idx_d;
      rank_q      <= rank_d;
      sel_q       <= sel_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      out_mask_q  <= out_mask_d;
      out_value_q <= out_value_d;
      out_err_q   <= out_err_d;
    end
  end

  assign busy_o          = state_q == S_CLEAR;
  assign out_valid_o     = out_valid_q;
  assign hit_mask_o      = out_mask_q;
  assign counter_value_o = out_value_q;
  assign error_o         = out_err_q;

endmodule

>>> design/topk_recall_hit_counter.sv
// Top level of the top-k recall hit counter (recall-at-rank histogram).
// Instantiates trhc_cfg_regs, trhc_front, trhc_queue and trhc_back; uses trhc_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   action, point_index, rank_position,
//                                                 slot_select
//   output   out        out_valid_o / out_stall_i hit_mask, counter_value, error
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Every input transaction yields exactly one output transaction, in order.
// In the back end a new query, a ground-truth entry or a rejected item is answered
// from the idle state, and a counter read from the readout state. A
// candidate with no ground truth in reach is answered from the idle state too;
// otherwise the ground-truth memory is scanned one entry per cycle through its
// single read port, over at most the largest min(k, entries held) among the
// active slots, then the counter row is read, incremented and written back.
// After reset all MAX_CANDIDATES counter rows are cleared one row per cycle,
// with in_stall_o high; configuration writes are taken all the while.
// A two-entry queue lets the front accept transactions while the back works on
// a command or while a result waits in the output register under out_stall_i.
module topk_recall_hit_counter
  import trhc_pkg::*;
#(
  parameter int unsigned MAX_TRUTH      = MAX_TRUTH_DEF,
  parameter int unsigned TOPK_SLOTS     = TOPK_SLOTS_DEF,
  parameter int unsigned MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int unsigned COUNTER_BITS   = COUNTER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [INDEX_W-1:0]    point_index_i,
  input  logic [RANK_W-1:0]     rank_position_i,
  input  logic [SEL_W-1:0]      slot_select_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MASK_W-1:0]     hit_mask_o,
  output logic [VALUE_W-1:0]    counter_value_o,
  output logic                  error_o
);

  cfg_t cfg;
  logic busy;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_out;

  // Both ends read it directly; the user, not the block, keeps it static while idle.
  trhc_cfg_regs #(
    .TOPK_SLOTS (TOPK_SLOTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The front settles range checks that depend only on configuration, so the
  // back end sees rejected candidates and reads as a single reject command.
  trhc_front #(
    .TOPK_SLOTS     (TOPK_SLOTS),
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .point_index_i   (point_index_i),
    .rank_position_i (rank_position_i),
    .slot_select_i   (slot_select_i),
    .cfg_i           (cfg),
    .busy_i          (busy),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  trhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // The back end owns all query state: ground-truth list, its fill count and
  // the counter rows, one row per rank position holding every slot's counter.
  trhc_back #(
    .MAX_TRUTH      (MAX_TRUTH),
    .TOPK_SLOTS     (TOPK_SLOTS),
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_mask_o      (hit_mask_o),
    .counter_value_o (counter_value_o),
    .error_o         (error_o)
  );

endmodule
